>>> sv/rgbfb_pkg.sv
// -----------------------------------------------------------------------------
// RGB framebuffer blit package
// Register indexes, depth mode codes and pixel packing helpers shared by the
// blit datapath and its channel interfaces.
// -----------------------------------------------------------------------------
`default_nettype none

package rgbfb_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FRAME_BASE    = 3'd0;
   localparam logic [2:0] CSR_ROW_PITCH     = 3'd1;
   localparam logic [2:0] CSR_DEPTH_MODE    = 3'd2;
   localparam logic [2:0] CSR_BLIT_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_BLIT_HEIGHT   = 3'd4;
   localparam logic [2:0] CSR_IMAGE_WIDTH   = 3'd5;
   localparam logic [2:0] CSR_DEST_LEFT     = 3'd6;
   localparam logic [2:0] CSR_DEST_TOP      = 3'd7;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   // Color depth codes.
   localparam logic [2:0] DEPTH_INDEX8   = 3'd0;
   localparam logic [2:0] DEPTH_RGB555   = 3'd1;
   localparam logic [2:0] DEPTH_RGB565   = 3'd2;
   localparam logic [2:0] DEPTH_RGB888   = 3'd3;
   localparam logic [2:0] DEPTH_XRGB8888 = 3'd4;

   // Field widths.
   localparam int PitchWidth   = 20;
   localparam int SizeWidth    = 16;
   localparam int CoordSumWidth = SizeWidth + 1;
   localparam int RowOffWidth  = PitchWidth + CoordSumWidth;
   localparam int ColOffWidth  = CoordSumWidth + 2;

   // Bytes written per pixel for a depth mode.
   function automatic logic [2:0] pixel_bytes(input logic [2:0] mode);
      logic [2:0] bytes;
      unique case (mode)
         DEPTH_INDEX8:  bytes = 3'd1;
         DEPTH_RGB555:  bytes = 3'd2;
         DEPTH_RGB565:  bytes = 3'd2;
         DEPTH_RGB888:  bytes = 3'd3;
         default:       bytes = 3'd4;
      endcase
      return bytes;
   endfunction

   // Pack one pixel into the low bytes of a little-endian write word.
   function automatic logic [31:0] pack_pixel(input logic [2:0] mode,
                                              input logic [7:0] blue,
                                              input logic [7:0] green,
                                              input logic [7:0] red);
      logic [31:0] word;
      unique case (mode)
         DEPTH_INDEX8: word = {24'd0, blue};
         DEPTH_RGB555: word = {17'd0, red[7:3], green[7:3], blue[7:3]};
         DEPTH_RGB565: word = {16'd0, red[7:3], green[7:2], blue[7:3]};
         default:      word = {8'd0, red, green, blue};
      endcase
      return word;
   endfunction

   // Byte offset of a pixel within its row.
   function automatic logic [ColOffWidth-1:0] column_offset(
      input logic [2:0]               mode,
      input logic [CoordSumWidth-1:0] column);
      logic [ColOffWidth-1:0] col_wide;
      logic [ColOffWidth-1:0] offset;
      col_wide = ColOffWidth'(column);
      unique case (mode)
         DEPTH_INDEX8: offset = col_wide;
         DEPTH_RGB555: offset = col_wide << 1;
         DEPTH_RGB565: offset = col_wide << 1;
         DEPTH_RGB888: offset = (col_wide << 1) + col_wide;
         default:      offset = col_wide << 2;
      endcase
      return offset;
   endfunction

endpackage

`default_nettype wire

>>> sv/rgbfb_if.sv
// -----------------------------------------------------------------------------
// RGB framebuffer blit channel interfaces
// Pixel request channel, framebuffer write response channel and register
// write channel, each with a valid/ready handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface rgbfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_or_index;
   logic [7:0] green_byte;
   logic [7:0] red_byte;

   modport source (output valid, blue_or_index, green_byte, red_byte, input ready);
   modport sink   (input valid, blue_or_index, green_byte, red_byte, output ready);
endinterface

interface rgbfb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] write_address;
   logic [31:0] write_data;
   logic [2:0]  byte_count;
   logic        last_write;

   modport source (output valid, write_address, write_data, byte_count, last_write,
                   input ready);
   modport sink   (input valid, write_address, write_data, byte_count, last_write,
                   output ready);
endinterface

interface rgbfb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [rgbfb_pkg::CsrIndexWidth-1:0] index;
   logic [rgbfb_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/rgb_image_framebuffer_blit.sv
// -----------------------------------------------------------------------------
// RGB image framebuffer blit
// Turns a row-ordered source pixel stream into packed framebuffer writes.
// -----------------------------------------------------------------------------
// Throughput: one pixel request per cycle while the response channel does not stall;
// padding pixels leave a bubble. An accepted request passes the decode/count stage,
// the row-pitch multiply stage and the address add into the output register.
// A stalled response holds the pipeline; empty stages still fill behind it.
// Reset clears the counters, all configuration registers (depth mode to 32-bit xRGB) and
// the pipeline valid bits.
`default_nettype none

module rgb_image_framebuffer_blit #(
   parameter int ADDR_WIDTH  = 32,
   parameter int COORD_WIDTH = 16
) (
   input  wire            clock,
   input  wire            reset,
   rgbfb_req_if.sink      req_bus,
   rgbfb_rsp_if.source    rsp_bus,
   rgbfb_csr_if.sink      csr_bus
);

   localparam int SumW = rgbfb_pkg::CoordSumWidth;

   // Configuration registers.
   logic [31:0]                          frame_base_ff;
   logic [rgbfb_pkg::PitchWidth-1:0]     row_pitch_ff;
   logic [2:0]                           depth_mode_ff;
   logic [rgbfb_pkg::SizeWidth-1:0]      blit_width_ff;
   logic [rgbfb_pkg::SizeWidth-1:0]      blit_height_ff;
   logic [rgbfb_pkg::SizeWidth-1:0]      image_width_ff;
   logic [rgbfb_pkg::SizeWidth-1:0]      dest_left_ff;
   logic [rgbfb_pkg::SizeWidth-1:0]      dest_top_ff;

   // Position counters.
   logic [COORD_WIDTH-1:0] column_ff, column_in;
   logic [COORD_WIDTH-1:0] row_ff, row_in;

   // Decode stage.
   logic                 s1_valid_ff;
   logic [SumW-1:0]      s1_top_row_ff;
   logic [SumW-1:0]      s1_left_col_ff;
   logic [7:0]           s1_blue_ff, s1_green_ff, s1_red_ff;
   logic                 s1_last_ff;

   // Multiply stage.
   logic                                s2_valid_ff;
   logic [rgbfb_pkg::RowOffWidth-1:0]   s2_row_off_ff;
   logic [rgbfb_pkg::ColOffWidth-1:0]   s2_col_off_ff;
   logic [31:0]                         s2_data_ff;
   logic [2:0]                          s2_count_ff;
   logic                                s2_last_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_address_ff, rsp_address_in;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_count_ff;
   logic        rsp_last_ff;

   logic                     req_accept;
   logic                     out_ready, s2_ready, s1_ready;
   logic [SumW-1:0]          col_ext, row_ext, col_plus, row_plus;
   logic [rgbfb_pkg::SizeWidth-1:0] row_len;
   logic                     row_end, image_end, write_hit, last_hit;
   logic [ADDR_WIDTH-1:0]    address_full;

   // Each stage moves when the next one is empty or moving.
   assign out_ready  = !rsp_valid_ff || rsp_bus.ready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;
   assign req_accept = req_bus.valid && s1_ready;

   assign csr_bus.ready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff    <= '0;
         row_pitch_ff     <= '0;
         depth_mode_ff    <= rgbfb_pkg::DEPTH_XRGB8888;
         blit_width_ff    <= '0;
         blit_height_ff   <= '0;
         image_width_ff   <= '0;
         dest_left_ff     <= '0;
         dest_top_ff      <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            rgbfb_pkg::CSR_FRAME_BASE:    frame_base_ff    <= csr_bus.data;
            rgbfb_pkg::CSR_ROW_PITCH:
               row_pitch_ff <= csr_bus.data[rgbfb_pkg::PitchWidth-1:0];
            rgbfb_pkg::CSR_DEPTH_MODE:    depth_mode_ff    <= csr_bus.data[2:0];
            rgbfb_pkg::CSR_BLIT_WIDTH:
               blit_width_ff  <= csr_bus.data[rgbfb_pkg::SizeWidth-1:0];
            rgbfb_pkg::CSR_BLIT_HEIGHT:
               blit_height_ff <= csr_bus.data[rgbfb_pkg::SizeWidth-1:0];
            rgbfb_pkg::CSR_IMAGE_WIDTH:
               image_width_ff <= csr_bus.data[rgbfb_pkg::SizeWidth-1:0];
            rgbfb_pkg::CSR_DEST_LEFT:
               dest_left_ff   <= csr_bus.data[rgbfb_pkg::SizeWidth-1:0];
            rgbfb_pkg::CSR_DEST_TOP:
               dest_top_ff    <= csr_bus.data[rgbfb_pkg::SizeWidth-1:0];
            default: ;
         endcase
      end
   end

   // Position decode and next counter values.
   always_comb begin
      col_ext   = SumW'(column_ff);
      row_ext   = SumW'(row_ff);
      col_plus  = col_ext + SumW'(1);
      row_plus  = row_ext + SumW'(1);
      row_len   = (image_width_ff < blit_width_ff) ? blit_width_ff : image_width_ff;
      row_end   = col_plus >= SumW'(row_len);
      image_end = row_plus >= SumW'(blit_height_ff);
      write_hit = (depth_mode_ff <= rgbfb_pkg::DEPTH_XRGB8888)
                  && (col_ext < SumW'(blit_width_ff))
                  && (row_ext < SumW'(blit_height_ff));
      last_hit  = (row_plus == SumW'(blit_height_ff))
                  && (col_plus == SumW'(blit_width_ff));
      column_in = column_ff;
      row_in    = row_ff;
      if (row_end) begin
         column_in = '0;
         row_in    = image_end ? '0 : row_plus[COORD_WIDTH-1:0];
      end else begin
         column_in = col_plus[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (req_accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // Decode stage: padding, out-of-range and invalid-depth pixels are dropped here.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_accept && write_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_top_row_ff  <= SumW'(dest_top_ff) + row_ext;
         s1_left_col_ff <= SumW'(dest_left_ff) + col_ext;
         s1_blue_ff     <= req_bus.blue_or_index;
         s1_green_ff    <= req_bus.green_byte;
         s1_red_ff      <= req_bus.red_byte;
         s1_last_ff     <= last_hit;
      end
   end

   // Multiply stage: row pitch product, column offset and pixel packing.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_row_off_ff <= rgbfb_pkg::RowOffWidth'(row_pitch_ff)
                          * rgbfb_pkg::RowOffWidth'(s1_top_row_ff);
         s2_col_off_ff <= rgbfb_pkg::column_offset(depth_mode_ff, s1_left_col_ff);
         s2_data_ff    <= rgbfb_pkg::pack_pixel(depth_mode_ff, s1_blue_ff,
                                                s1_green_ff, s1_red_ff);
         s2_count_ff   <= rgbfb_pkg::pixel_bytes(depth_mode_ff);
         s2_last_ff    <= s1_last_ff;
      end
   end

   // Address sum, wrapped to the address width and presented as 32 bits.
   assign address_full = ADDR_WIDTH'(frame_base_ff) + ADDR_WIDTH'(s2_row_off_ff)
                         + ADDR_WIDTH'(s2_col_off_ff);
   assign rsp_address_in = 32'(address_full);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_address_ff <= rsp_address_in;
         rsp_data_ff    <= s2_data_ff;
         rsp_count_ff   <= s2_count_ff;
         rsp_last_ff    <= s2_last_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.write_address = rsp_address_ff;
   assign rsp_bus.write_data    = rsp_data_ff;
   assign rsp_bus.byte_count    = rsp_count_ff;
   assign rsp_bus.last_write    = rsp_last_ff;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// -----------------------------------------------------------------------------
// Framebuffer blit testbench
// Streams source pixels through rgb_image_framebuffer_blit under random
// register settings and random handshake gaps on both channels. A scoreboard
// tracks the block's counters and registers, works out every framebuffer
// write that a pixel request causes, and compares the responses in order.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 1800;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;

   // One framebuffer write as it appears on the response channel.
   typedef struct packed {
      logic [31:0] address;
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } fb_write_type;

   // Scoreboard: keeps its own copy of the registers and the row/column
   // counters, and queues the writes that accepted pixels should produce.
   class blit_write_predictor_type;
      logic [31:0]  frame_base;
      logic [19:0]  row_pitch;
      logic [2:0]   depth_mode;
      logic [15:0]  blit_width;
      logic [15:0]  blit_height;
      logic [15:0]  image_width;
      logic [15:0]  dest_left;
      logic [15:0]  dest_top;
      logic [15:0]  col_idx;
      logic [15:0]  row_idx;
      fb_write_type pending_writes[$];
      int           error_count;

      function new();
         frame_base    = '0;
         row_pitch     = '0;
         depth_mode    = rgbfb_pkg::DEPTH_XRGB8888;
         blit_width    = '0;
         blit_height   = '0;
         image_width   = '0;
         dest_left     = '0;
         dest_top      = '0;
         col_idx       = '0;
         row_idx       = '0;
         error_count   = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            rgbfb_pkg::CSR_FRAME_BASE:  frame_base  = value;
            rgbfb_pkg::CSR_ROW_PITCH:   row_pitch   = value[19:0];
            rgbfb_pkg::CSR_DEPTH_MODE:  depth_mode  = value[2:0];
            rgbfb_pkg::CSR_BLIT_WIDTH:  blit_width  = value[15:0];
            rgbfb_pkg::CSR_BLIT_HEIGHT: blit_height = value[15:0];
            rgbfb_pkg::CSR_IMAGE_WIDTH: image_width = value[15:0];
            rgbfb_pkg::CSR_DEST_LEFT:   dest_left   = value[15:0];
            rgbfb_pkg::CSR_DEST_TOP:    dest_top    = value[15:0];
            default: ;
         endcase
      endfunction

      // The source row is never shorter than the blit width.
      function logic [31:0] row_length();
         return (image_width < blit_width) ? 32'(blit_width) : 32'(image_width);
      endfunction

      // Number of pixels still needed to bring the counters back to zero.
      function logic [31:0] pixels_left_in_image();
         logic [31:0] len;
         logic [31:0] first;
         len   = row_length();
         first = (32'(col_idx) + 32'd1 >= len) ? 32'd1 : len - 32'(col_idx);
         if (32'(row_idx) + 32'd1 >= 32'(blit_height))
            return first;
         return first + (32'(blit_height) - 32'(row_idx) - 32'd1) * len;
      endfunction

      function void note_pixel(logic [7:0] blue, logic [7:0] green, logic [7:0] red);
         logic [63:0]  row_base;
         logic [63:0]  addr;
         logic [31:0]  packed_px;
         logic [2:0]   nbytes;
         logic [31:0]  len;
         fb_write_type w;
         len      = row_length();
         row_base = 64'(frame_base) + 64'(row_pitch) * (64'(dest_top) + 64'(row_idx));
         row_base = {32'd0, row_base[31:0]};

         // Only pixels inside the blit rectangle with a valid depth are written.
         if (depth_mode <= rgbfb_pkg::DEPTH_XRGB8888 && col_idx < blit_width
             && row_idx < blit_height) begin
            case (depth_mode)
               rgbfb_pkg::DEPTH_INDEX8: begin
                  nbytes    = 3'd1;
                  packed_px = 32'(blue);
               end
               rgbfb_pkg::DEPTH_RGB555: begin
                  nbytes    = 3'd2;
                  packed_px = (32'(red >> 3) << 10) | (32'(green >> 3) << 5)
                              | 32'(blue >> 3);
               end
               rgbfb_pkg::DEPTH_RGB565: begin
                  nbytes    = 3'd2;
                  packed_px = (32'(red >> 3) << 11) | (32'(green >> 2) << 5)
                              | 32'(blue >> 3);
               end
               rgbfb_pkg::DEPTH_RGB888: begin
                  nbytes    = 3'd3;
                  packed_px = (32'(red) << 16) | (32'(green) << 8) | 32'(blue);
               end
               default: begin
                  nbytes    = 3'd4;
                  packed_px = (32'(red) << 16) | (32'(green) << 8) | 32'(blue);
               end
            endcase
            addr      = row_base + 64'(nbytes) * (64'(dest_left) + 64'(col_idx));
            w.address = addr[31:0];
            w.data    = packed_px;
            w.nbytes  = nbytes;
            w.last    = (32'(row_idx) + 32'd1 == 32'(blit_height)) &&
                        (32'(col_idx) + 32'd1 == 32'(blit_width));
            pending_writes.push_back(w);
         end

         // Advance the counters; the image wraps back to row zero.
         if (32'(col_idx) + 32'd1 >= len) begin
            col_idx = '0;
            if (32'(row_idx) + 32'd1 >= 32'(blit_height))
               row_idx = '0;
            else
               row_idx = row_idx + 16'd1;
         end else begin
            col_idx = col_idx + 16'd1;
         end
      endfunction

      function void check_write(fb_write_type got);
         fb_write_type want;
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write: address %h data %h bytes %0d last %0b",
                     $time, got.address, got.data, got.nbytes, got.last);
            error_count++;
            return;
         end
         want = pending_writes.pop_front();
         if (got.address !== want.address) begin
            $display("%0t: write_address expected %h, got %h", $time, want.address,
                     got.address);
            error_count++;
         end
         if (got.data !== want.data) begin
            $display("%0t: write_data expected %h, got %h", $time, want.data, got.data);
            error_count++;
         end
         if (got.nbytes !== want.nbytes) begin
            $display("%0t: byte_count expected %0d, got %0d", $time, want.nbytes,
                     got.nbytes);
            error_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_write expected %0b, got %0b", $time, want.last, got.last);
            error_count++;
         end
      endfunction

      function void close_out();
         if (pending_writes.size() != 0) begin
            $display("%0t: %0d expected writes never arrived", $time,
                     pending_writes.size());
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rgbfb_req_if req_bus ();
   rgbfb_rsp_if rsp_bus ();
   rgbfb_csr_if csr_bus ();

   blit_write_predictor_type sb;
   logic [31:0] next_regs [8];
   bit          req_steady;
   bit          rsp_steady;
   int          pixels_sent;
   int          idle_cycles;

   rgb_image_framebuffer_blit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5ns clock = ~clock;

   // Record accepted pixel requests, then check accepted writes.
   always @(posedge clock) begin
      fb_write_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_pixel(req_bus.blue_or_index, req_bus.green_byte, req_bus.red_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.address = rsp_bus.write_address;
            got.data    = rsp_bus.write_data;
            got.nbytes  = rsp_bus.byte_count;
            got.last    = rsp_bus.last_write;
            sb.check_write(got);
         end
      end
   end

   // Watchdog: ends the run when no handshake completes for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Write receiver: stalls a random number of cycles before each write.
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red);
      int unsigned gap;
      gap = req_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.blue_or_index <= blue;
      req_bus.green_byte    <= green;
      req_bus.red_byte      <= red;
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;
   endtask

   task automatic send_random_pixels(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Stop sending and let every outstanding write, and any padding pixel
   // still in flight, leave the pipeline.
   task automatic drain_writes();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic stage_regs(input logic [31:0] base, input logic [31:0] pitch,
                             input logic [2:0] depth, input logic [15:0] bw,
                             input logic [15:0] bh, input logic [15:0] iw,
                             input logic [15:0] left, input logic [15:0] top);
      next_regs[rgbfb_pkg::CSR_FRAME_BASE]  = base;
      next_regs[rgbfb_pkg::CSR_ROW_PITCH]   = pitch;
      next_regs[rgbfb_pkg::CSR_DEPTH_MODE]  = 32'(depth);
      next_regs[rgbfb_pkg::CSR_BLIT_WIDTH]  = 32'(bw);
      next_regs[rgbfb_pkg::CSR_BLIT_HEIGHT] = 32'(bh);
      next_regs[rgbfb_pkg::CSR_IMAGE_WIDTH] = 32'(iw);
      next_regs[rgbfb_pkg::CSR_DEST_LEFT]   = 32'(left);
      next_regs[rgbfb_pkg::CSR_DEST_TOP]    = 32'(top);
   endtask

   // Write the staged registers selected by mask. With noisy set, the bits
   // above each register's width carry random values.
   task automatic load_config(input logic [7:0] mask, input bit noisy);
      logic [31:0] word;
      logic [31:0] keep;
      logic [2:0]  idx;
      for (int i = 0; i < 8; i++) begin
         idx = 3'(i);
         if (mask[idx]) begin
            case (idx)
               rgbfb_pkg::CSR_FRAME_BASE: keep = 32'hFFFF_FFFF;
               rgbfb_pkg::CSR_ROW_PITCH:  keep = 32'h000F_FFFF;
               rgbfb_pkg::CSR_DEPTH_MODE: keep = 32'h0000_0007;
               default:                   keep = 32'h0000_FFFF;
            endcase
            word = next_regs[idx];
            if (noisy)
               word = (word & keep) | ($urandom & ~keep);
            @(negedge clock);
            csr_bus.valid <= 1'b1;
            csr_bus.index <= idx;
            csr_bus.data  <= word;
            do @(posedge clock); while (!csr_bus.ready);
            sb.set_register(idx, word);
         end
      end
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] bw;
      logic [15:0] bh;
      logic [15:0] iw;
      logic [2:0]  depth;
      logic [31:0] pitch;
      logic [31:0] count;
      logic [7:0]  mask;
      bit          big;

      sb = new();
      req_bus.valid         = 1'b0;
      req_bus.blue_or_index = '0;
      req_bus.green_byte    = '0;
      req_bus.red_byte      = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      req_steady            = 1'b0;
      rsp_steady            = 1'b0;
      pixels_sent           = 0;
      idle_cycles           = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings describe an empty image: nothing is written.
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      drain_writes();

      // 8-bit index mode with every address term at its maximum, so the
      // address wraps; the third column of each row is padding.
      stage_regs(32'hFFFF_FFFF, 32'h000F_FFFF, rgbfb_pkg::DEPTH_INDEX8, 16'd2, 16'd2,
                 16'd3, 16'hFFFF, 16'hFFFF);
      load_config(8'hFF, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
      drain_writes();

      // Each remaining depth on a one-pixel image, then the unused codes.
      stage_regs(32'h1000_0000, 32'd640, rgbfb_pkg::DEPTH_RGB555, 16'd1, 16'd1, 16'd1,
                 16'd5, 16'd7);
      load_config(8'hFF, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      drain_writes();
      next_regs[rgbfb_pkg::CSR_DEPTH_MODE] = 32'(rgbfb_pkg::DEPTH_RGB565);
      load_config(8'h01 << rgbfb_pkg::CSR_DEPTH_MODE, 1'b0);
      send_pixel(8'h00, 8'hFF, 8'h00);
      drain_writes();
      next_regs[rgbfb_pkg::CSR_DEPTH_MODE] = 32'(rgbfb_pkg::DEPTH_RGB888);
      load_config(8'h01 << rgbfb_pkg::CSR_DEPTH_MODE, 1'b0);
      send_pixel(8'hA5, 8'h5A, 8'hC3);
      drain_writes();
      next_regs[rgbfb_pkg::CSR_DEPTH_MODE] = 32'(rgbfb_pkg::DEPTH_XRGB8888);
      load_config(8'h01 << rgbfb_pkg::CSR_DEPTH_MODE, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      drain_writes();
      for (int d = 32'(rgbfb_pkg::DEPTH_XRGB8888) + 1; d < 8; d++) begin
         next_regs[rgbfb_pkg::CSR_DEPTH_MODE] = 32'(d);
         load_config(8'h01 << rgbfb_pkg::CSR_DEPTH_MODE, 1'b0);
         send_pixel(8'hFF, 8'hFF, 8'hFF);
         drain_writes();
      end

      // Largest image, left after two pixels; then the size shrinks under
      // the running counters.
      stage_regs(32'd0, 32'd0, rgbfb_pkg::DEPTH_XRGB8888, 16'hFFFF, 16'hFFFF, 16'd0,
                 16'd0, 16'd0);
      load_config(8'hFF, 1'b0);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_pixel(8'hFE, 8'hDC, 8'hBA);
      drain_writes();
      next_regs[rgbfb_pkg::CSR_BLIT_WIDTH]  = 32'd3;
      next_regs[rgbfb_pkg::CSR_BLIT_HEIGHT] = 32'd2;
      load_config((8'h01 << rgbfb_pkg::CSR_BLIT_WIDTH)
                  | (8'h01 << rgbfb_pkg::CSR_BLIT_HEIGHT), 1'b0);
      send_pixel(8'h0F, 8'hF0, 8'h3C);
      drain_writes();

      // Counters end up on a row beyond a newly lowered blit height.
      next_regs[rgbfb_pkg::CSR_BLIT_WIDTH]  = 32'd1;
      next_regs[rgbfb_pkg::CSR_BLIT_HEIGHT] = 32'd5;
      load_config((8'h01 << rgbfb_pkg::CSR_BLIT_WIDTH)
                  | (8'h01 << rgbfb_pkg::CSR_BLIT_HEIGHT), 1'b0);
      send_random_pixels(3);
      drain_writes();
      next_regs[rgbfb_pkg::CSR_BLIT_HEIGHT] = 32'd2;
      load_config(8'h01 << rgbfb_pkg::CSR_BLIT_HEIGHT, 1'b0);
      send_pixel(8'h81, 8'h42, 8'h24);
      drain_writes();

      // Random images: mostly complete ones, some cut short or huge.
      while (pixels_sent < ITEM_TARGET) begin
         big = ($urandom_range(0, 19) == 0);
         bw  = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
         bh  = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         case ($urandom_range(0, 2))
            0:       iw = 16'd0;
            1:       iw = bw + 16'($urandom_range(0, 4));
            default: iw = 16'($urandom_range(0, 10));
         endcase
         if (big) begin
            case ($urandom_range(0, 2))
               0:       bw = 16'hFFFF;
               1:       bh = 16'hFFFF;
               default: iw = 16'hFFFF;
            endcase
         end
         if ($urandom_range(0, 9) == 0)
            depth = 3'($urandom_range(32'(rgbfb_pkg::DEPTH_XRGB8888) + 1, 7));
         else
            depth = 3'($urandom_range(rgbfb_pkg::DEPTH_INDEX8,
                                      rgbfb_pkg::DEPTH_XRGB8888));
         case ($urandom_range(0, 3))
            0:       pitch = 32'($urandom_range(0, 4096));
            1:       pitch = 32'h000F_FFFF;
            default: pitch = $urandom & 32'h000F_FFFF;
         endcase
         stage_regs($urandom, pitch, depth, bw, bh, iw,
                    ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom));
         mask = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
         load_config(mask, $urandom_range(0, 1) == 1);

         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         count      = sb.pixels_left_in_image();
         if (big || $urandom_range(0, 9) == 0 || count > 200)
            count = $urandom_range(1, 40);
         send_random_pixels(count);
         drain_writes();
      end

      req_steady = 1'b0;
      rsp_steady = 1'b0;
      sb.close_out();
      if (sb.error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> sim.f
sv/rgbfb_pkg.sv
sv/rgbfb_if.sv
sv/rgb_image_framebuffer_blit.sv
bench/testbench.sv
